// ===== hw/rtl/grid_mesh_index_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Grid mesh index generator assertion macros
// Shared concurrent assertion helpers for the grid mesh index generator RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_MESH_INDEX_GENERATOR_CORE_DEFINES_SVH
`define GRID_MESH_INDEX_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define GMIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("grid mesh index generator: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GMIG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("grid mesh index generator: assertion failed");
`else
`define GMIG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GMIG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/gmig_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid mesh index generator package
// Types, register indexes and constants shared by the index generator RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package gmig_pkg;

	// Largest grid dimension; configured sizes saturate to [2, MAX_GRID_DIM].
	localparam int MAX_GRID_DIM = 4096;

	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int INDEX_W = 24;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRI_MODE    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 13'd1024;
	localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 13'd1024;

	// Number of indices a vertex emits.
	localparam logic [2:0] RUN_NONE  = 3'd0;
	localparam logic [2:0] RUN_STRIP = 3'd2;
	localparam logic [2:0] RUN_ROW_END = 3'd4;
	localparam logic [2:0] RUN_TRI   = 3'd6;

	// Input command: one grid vertex coordinate.
	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
	} cmd_t;

	// One emitted mesh index.
	typedef struct packed {
		logic [INDEX_W-1:0] vertex_index;
		logic               last_of_run;
	} result_t;

	// Saturate a configured dimension into the supported range.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < 13'd2) begin
			r = 13'd2;
		end else if (v > DIM_W'(MAX_GRID_DIM)) begin
			r = DIM_W'(MAX_GRID_DIM);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/grid_mesh_index_generator_core.sv =====
// ----------------------------------------------------------------------------
// Grid mesh index generator core
// Turns grid vertex coordinates into triangle strip or triangle list indices.
// ----------------------------------------------------------------------------
// A command transfer takes place at a rising edge with start high and busy
// low. The coordinate is registered in the input stage, the indices are
// computed from it with one 12x13 multiply and a few adds and loaded into the
// emit stage, and the results then leave on the result port one per cycle
// through the output register. An item emits as many results as its run
// holds (2 for a strip vertex, 4 at a strip row end, 6 for a triangle-list
// cell), or none. The next command is taken while the previous one is
// still emitting. The receiver cannot stall: every strobe is a transfer.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

`include "grid_mesh_index_generator_core_defines.svh"

module grid_mesh_index_generator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port
	input  wire logic                             cfg_wr_en,
	input  wire logic [gmig_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gmig_pkg::DIM_W-1:0]       cfg_wdata,
	// Command side
	input  wire logic                             start,
	input  wire gmig_pkg::cmd_t                   cmd,
	output logic                                  busy,
	// Result side
	output logic                                  result_strobe,
	output gmig_pkg::result_t                     result
);

	// Configuration registers
	logic [gmig_pkg::DIM_W-1:0] grid_width_q;
	logic [gmig_pkg::DIM_W-1:0] grid_height_q;
	logic                       tri_mode_q;

	// Input stage
	logic           valid_s1;
	gmig_pkg::cmd_t cmd_s1;

	// Emit stage
	logic                         valid_s2;
	logic                         mode_s2;
	logic [2:0]                   cnt_s2;
	logic [2:0]                   pos_s2;
	logic [gmig_pkg::INDEX_W-1:0] c_s2;
	logic [gmig_pkg::INDEX_W-1:0] u_s2;
	logic [gmig_pkg::INDEX_W-1:0] base_s2;

	// Output register
	logic              strobe_q;
	gmig_pkg::result_t result_q;

	// Compute-stage signals
	logic [gmig_pkg::DIM_W-1:0]   w_eff;
	logic [gmig_pkg::DIM_W-1:0]   h_eff;
	logic [gmig_pkg::DIM_W-1:0]   x_ext;
	logic [gmig_pkg::DIM_W-1:0]   y_ext;
	logic [gmig_pkg::INDEX_W-1:0] prod;
	logic [gmig_pkg::INDEX_W-1:0] c_c;
	logic [gmig_pkg::INDEX_W-1:0] base_c;
	logic [gmig_pkg::INDEX_W-1:0] u_c;
	logic [2:0]                   cnt_c;
	logic                         last_s2;
	logic                         load_s2;
	logic                         accept;
	logic [gmig_pkg::INDEX_W-1:0] sel_index;

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gmig_pkg::GRID_WIDTH_RST;
			grid_height_q <= gmig_pkg::GRID_HEIGHT_RST;
			tri_mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gmig_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				gmig_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				gmig_pkg::REG_TRI_MODE:    tri_mode_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage drains when the emit stage is free or ends.
	assign last_s2 = (pos_s2 == (cnt_s2 - 3'd1));
	assign load_s2 = valid_s1 && (!valid_s2 || last_s2);
	assign busy    = valid_s1 && !load_s2;
	assign accept  = start && !busy;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// Index arithmetic: row base of the next row, current and lower index.
	always_comb begin
		w_eff  = gmig_pkg::clamp_dim(grid_width_q);
		h_eff  = gmig_pkg::clamp_dim(grid_height_q);
		x_ext  = {1'b0, cmd_s1.cell_x};
		y_ext  = {1'b0, cmd_s1.cell_y};
		prod   = gmig_pkg::INDEX_W'(cmd_s1.cell_y) * gmig_pkg::INDEX_W'(w_eff);
		c_c    = prod + gmig_pkg::INDEX_W'(x_ext);
		base_c = prod + gmig_pkg::INDEX_W'(w_eff);
		u_c    = base_c + gmig_pkg::INDEX_W'(x_ext);
	end

	// Number of results; the last row, outside coordinates and, in triangle-list mode, the last column emit none.
	always_comb begin
		cnt_c = gmig_pkg::RUN_NONE;
		if (x_ext < w_eff && y_ext < (h_eff - 13'd1)) begin
			if (tri_mode_q) begin
				if (x_ext < (w_eff - 13'd1)) begin
					cnt_c = gmig_pkg::RUN_TRI;
				end
			end else if (x_ext == (w_eff - 13'd1) && y_ext < (h_eff - 13'd2)) begin
				cnt_c = gmig_pkg::RUN_ROW_END;
			end else begin
				cnt_c = gmig_pkg::RUN_STRIP;
			end
		end
	end

	// Emit stage control: one result per cycle until the run ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_s2   <= 3'd0;
			cnt_s2   <= gmig_pkg::RUN_NONE;
		end else if (load_s2) begin
			valid_s2 <= (cnt_c != gmig_pkg::RUN_NONE);
			pos_s2   <= 3'd0;
			cnt_s2   <= cnt_c;
		end else if (valid_s2) begin
			if (last_s2) begin
				valid_s2 <= 1'b0;
			end else begin
				pos_s2 <= pos_s2 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			mode_s2 <= tri_mode_q;
			c_s2    <= c_c;
			u_s2    <= u_c;
			base_s2 <= base_c;
		end
	end

	// Index selection by position in the run.
	always_comb begin
		sel_index = c_s2;
		if (mode_s2) begin
			case (pos_s2)
				3'd0:    sel_index = u_s2 + 24'd1;
				3'd1:    sel_index = c_s2 + 24'd1;
				3'd2:    sel_index = c_s2;
				3'd3:    sel_index = c_s2;
				3'd4:    sel_index = u_s2;
				3'd5:    sel_index = u_s2 + 24'd1;
				default: sel_index = c_s2;
			endcase
		end else begin
			case (pos_s2)
				3'd0:    sel_index = c_s2;
				3'd1:    sel_index = u_s2;
				3'd2:    sel_index = u_s2;
				3'd3:    sel_index = base_s2;
				default: sel_index = c_s2;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_q.vertex_index <= sel_index;
			result_q.last_of_run  <= last_s2;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	// Assertions
	`GMIG_ASSERT_IMP(a_pos_in_run, clk, arst_n, valid_s2, pos_s2 < cnt_s2)
	`GMIG_ASSERT_NXT(a_emit_strobes, clk, arst_n, valid_s2, strobe_q)
	`GMIG_ASSERT_IMP(a_busy_holds_item, clk, arst_n, busy, valid_s1 && valid_s2)
	`GMIG_ASSERT_NXT(a_run_ends, clk, arst_n, valid_s2 && last_s2 && !load_s2, !valid_s2)

endmodule

`default_nettype wire
